// ===== design/fnt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnt_pkg
// types and constants for the node freshness table
// ----------------------------------------------------------------------------
package fnt_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PORT_W = 2;
    localparam int unsigned SEQ_W  = 16;
    localparam int unsigned TICK_W = 16;
    localparam int unsigned SLOT_W = 4;

    localparam logic [TICK_W-1:0] SILENCE_RESET = 16'd2;

    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [SEQ_W-1:0]  seq;
        logic [TICK_W-1:0] heard;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_WRITE0,
        ST_RESULT
    } state_t;

    // serial-number compare: newer when the forward distance is nonzero and below half range
    function automatic logic seq_newer(input logic [SEQ_W-1:0] incoming,
                                       input logic [SEQ_W-1:0] stored);
        logic [SEQ_W-1:0] diff;
        diff = incoming - stored;
        return (diff != '0) && !diff[SEQ_W-1];
    endfunction

endpackage : fnt_pkg
`default_nettype wire

// ===== design/freshness_node_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// tick item: result state, then output register; next item once back in idle
// update item: one scanned entry at a time over a registered entry memory read;
//   a full table is scanned, every entry but the last copied one place down and
//   entry 0 written, with the input stalled meanwhile, one item at a time
// reset: per-entry valid flops clear the table at once, no clearing pass;
//   tick counter to zero, silence limit to 2
// ----------------------------------------------------------------------------
// freshness_node_table
// routing node table with tick aging, sequence checks and shift-down on full
// ----------------------------------------------------------------------------
module freshness_node_table
    import fnt_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_wr_en,
    input  wire logic [TICK_W-1:0] cfg_wr_data,

    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              func,
    input  wire logic [PORT_W-1:0] port,
    input  wire logic [SEQ_W-1:0]  seq_num,
    input  wire logic [ADDR_W-1:0] node_addr,

    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   accepted,
    output logic [SLOT_W-1:0]      slot,
    output logic                   shifted
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] PRELAST_IDX = IDX_W'(ENTRIES - 2);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    state_t state_reg, state_next;

    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [TICK_W-1:0] max_sil_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic [ADDR_W-1:0] req_addr_reg;
    logic [PORT_W-1:0] req_port_reg;
    logic [SEQ_W-1:0]  req_seq_reg;

    logic              res_acc_reg, res_acc_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_sh_reg, res_sh_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_acc_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_sh_reg;

    logic             in_xfer;
    logic             out_free;
    logic             load_out;
    logic [TICK_W-1:0] age;
    logic             live;
    logic             hit;
    logic             newer;

    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
    entry_t           new_entry;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == ST_RESULT) && out_free;

    assign age   = tick_reg - rd_data_reg.heard;
    assign live  = valid_reg[idx_reg] && (rd_data_reg.addr != '0) && (age <= max_sil_reg);
    assign hit   = (rd_data_reg.addr == req_addr_reg) && (rd_data_reg.port == req_port_reg);
    assign newer = seq_newer(req_seq_reg, rd_data_reg.seq);

    assign new_entry = '{addr: req_addr_reg, port: req_port_reg,
                         seq: req_seq_reg, heard: tick_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (func == FUNC_UPDATE) ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                if (!live || hit)
                begin
                    state_next = ST_RESULT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = (ENTRIES > 1) ? ST_SHIFT : ST_WRITE0;
                end
            end
            ST_SHIFT:
            begin
                if (idx_reg == IDX_W'(1))
                begin
                    state_next = ST_WRITE0;
                end
            end
            ST_WRITE0:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb
    begin
        idx_next      = idx_reg;
        tick_next     = tick_reg;
        valid_next    = valid_reg;
        res_acc_next  = res_acc_reg;
        res_slot_next = res_slot_reg;
        res_sh_next   = res_sh_reg;
        rd_idx        = '0;
        wr_en         = 1'b0;
        wr_idx        = idx_reg;
        wr_data       = new_entry;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next      = '0;
                res_acc_next  = 1'b0;
                res_slot_next = '0;
                res_sh_next   = 1'b0;
                if (in_xfer && (func == FUNC_TICK))
                begin
                    tick_next = tick_reg + TICK_W'(1);
                end
            end
            ST_SCAN:
            begin
                rd_idx = idx_reg + IDX_W'(1);
                if (!live || (hit && newer))
                begin
                    wr_en                = 1'b1;
                    valid_next[idx_reg]  = 1'b1;
                    res_acc_next         = 1'b1;
                    res_slot_next        = SLOT_W'(idx_reg);
                end
                else if (!hit && (idx_reg == LAST_IDX))
                begin
                    idx_next = LAST_IDX;
                    rd_idx   = PRELAST_IDX;
                end
                else if (!hit)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SHIFT:
            begin
                // rd_data_reg holds entry idx-1, copied one place down
                wr_en   = 1'b1;
                wr_data = rd_data_reg;
                if (idx_reg >= IDX_W'(2))
                begin
                    rd_idx = idx_reg - IDX_W'(2);
                end
                idx_next = idx_reg - IDX_W'(1);
            end
            ST_WRITE0:
            begin
                wr_en         = 1'b1;
                wr_idx        = '0;
                valid_next[0] = 1'b1;
                res_acc_next  = 1'b1;
                res_slot_next = '0;
                res_sh_next   = 1'b1;
            end
            ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tick_reg      <= '0;
            max_sil_reg   <= SILENCE_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                max_sil_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        res_acc_reg  <= res_acc_next;
        res_slot_reg <= res_slot_next;
        res_sh_reg   <= res_sh_next;
        if (in_xfer)
        begin
            req_addr_reg <= node_addr;
            req_port_reg <= port;
            req_seq_reg  <= seq_num;
        end
        if (load_out)
        begin
            out_acc_reg  <= res_acc_reg;
            out_slot_reg <= res_slot_reg;
            out_sh_reg   <= res_sh_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = out_acc_reg;
    assign slot      = out_slot_reg;
    assign shifted   = out_sh_reg;

endmodule : freshness_node_table
`default_nettype wire

// ===== bench/freshness_node_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// freshness_node_table_tb
// self-checking bench for the node freshness table, shadow table predicts
// accepted, slot and shifted for every input transfer; directed checks on the
// sequence compare, aging, zero addresses, shift-down and the silence limit
// edge, then random traffic, in most runs with random input gaps and output stalls
// ----------------------------------------------------------------------------
module freshness_node_table_tb
    import fnt_pkg::*;
();

    localparam int unsigned TABLE_ENTRIES = 16;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned POOL_MAX      = 24;
    localparam int unsigned DRAIN_CYCLES  = 2 * TABLE_ENTRIES + 8;

    typedef struct packed {
        logic              accepted;
        logic [SLOT_W-1:0] slot;
        logic              shifted;
    } outcome_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [TICK_W-1:0] cfg_wr_data = '0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic              func        = FUNC_TICK;
    logic [PORT_W-1:0] port        = '0;
    logic [SEQ_W-1:0]  seq_num     = '0;
    logic [ADDR_W-1:0] node_addr   = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic              accepted;
    logic [SLOT_W-1:0] slot;
    logic              shifted;

    // shadow copy of the table
    logic [ADDR_W-1:0] shadow_addr  [TABLE_ENTRIES];
    logic [PORT_W-1:0] shadow_port  [TABLE_ENTRIES];
    logic [SEQ_W-1:0]  shadow_seq   [TABLE_ENTRIES];
    logic [TICK_W-1:0] shadow_heard [TABLE_ENTRIES];
    logic [TICK_W-1:0] shadow_tick;
    logic [TICK_W-1:0] shadow_silence;

    outcome_t outcome_q[$];

    // address pool for random traffic
    logic [ADDR_W-1:0] pool_addr [POOL_MAX];
    logic [PORT_W-1:0] pool_port [POOL_MAX];
    logic [SEQ_W-1:0]  pool_seq  [POOL_MAX];

    bit gaps_on = 1'b1;
    int rx_hold = 0;
    int unsigned cycles = 0;
    int errors    = 0;
    int n_in      = 0;
    int n_ticks   = 0;
    int n_out     = 0;
    int n_stored  = 0;
    int n_shifted = 0;

    freshness_node_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .port        (port),
        .seq_num     (seq_num),
        .node_addr   (node_addr),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .accepted    (accepted),
        .slot        (slot),
        .shifted     (shifted)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("freshness_node_table_tb failed");
            $finish;
        end
    end

    function automatic void store_entry(input int idx, input logic [ADDR_W-1:0] a,
                                        input logic [PORT_W-1:0] p,
                                        input logic [SEQ_W-1:0] s);
        shadow_addr[idx]  = a;
        shadow_port[idx]  = p;
        shadow_seq[idx]   = s;
        shadow_heard[idx] = shadow_tick;
    endfunction

    function automatic outcome_t node_table_step(input logic f, input logic [PORT_W-1:0] p,
                                                 input logic [SEQ_W-1:0] s,
                                                 input logic [ADDR_W-1:0] a);
        outcome_t          res;
        logic [TICK_W-1:0] age;
        logic [SEQ_W-1:0]  fwd;
        int                i;
        res = '0;
        if (f == FUNC_TICK)
        begin
            shadow_tick = shadow_tick + 1'b1;
            return res;
        end
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            age = shadow_tick - shadow_heard[i];
            if (shadow_addr[i] == '0 || age > shadow_silence)
            begin
                store_entry(i, a, p, s);
                res.accepted = 1'b1;
                res.slot     = SLOT_W'(i);
                return res;
            end
            if (shadow_addr[i] == a && shadow_port[i] == p)
            begin
                // serial-number compare: forward distance nonzero and under half range
                fwd = s - shadow_seq[i];
                if (fwd != '0 && !fwd[SEQ_W-1])
                begin
                    store_entry(i, a, p, s);
                    res.accepted = 1'b1;
                    res.slot     = SLOT_W'(i);
                end
                return res;
            end
        end
        for (i = TABLE_ENTRIES - 1; i > 0; i--)
        begin
            shadow_addr[i]  = shadow_addr[i-1];
            shadow_port[i]  = shadow_port[i-1];
            shadow_seq[i]   = shadow_seq[i-1];
            shadow_heard[i] = shadow_heard[i-1];
        end
        store_entry(0, a, p, s);
        res.accepted = 1'b1;
        res.shifted  = 1'b1;
        return res;
    endfunction

    // result side: compare each transfer, then draw the stall for the next one
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_out++;
            if (outcome_q.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                errors++;
            end
            else
            begin
                want = outcome_q.pop_front();
                if (accepted !== want.accepted)
                begin
                    $error("accepted: expected %0d, actual %0d", want.accepted, accepted);
                    errors++;
                end
                if (slot !== want.slot)
                begin
                    $error("slot: expected %0d, actual %0d", want.slot, slot);
                    errors++;
                end
                if (shifted !== want.shifted)
                begin
                    $error("shifted: expected %0d, actual %0d", want.shifted, shifted);
                    errors++;
                end
                if (want.accepted)
                    n_stored++;
                if (want.shifted)
                    n_shifted++;
            end
            rx_hold = gaps_on ? $urandom_range(0, 15) : 0;
        end
        else if (out_valid && rx_hold != 0)
            rx_hold = rx_hold - 1;
        out_stall <= (rx_hold != 0);
    end

    task automatic send_item(input logic f, input logic [PORT_W-1:0] p,
                             input logic [SEQ_W-1:0] s, input logic [ADDR_W-1:0] a);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        port      <= p;
        seq_num   <= s;
        node_addr <= a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        outcome_q.push_back(node_table_step(f, p, s, a));
        n_in++;
        if (f == FUNC_TICK)
            n_ticks++;
    endtask

    task automatic wait_table_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_silence(input logic [TICK_W-1:0] limit);
        wait_table_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        shadow_silence = limit;
        @(posedge clk);
    endtask

    task automatic test_serial_compare();
        send_item(FUNC_UPDATE, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(FUNC_UPDATE, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(FUNC_UPDATE, 2'd3, 16'h7FFF, 32'hFFFF_FFFF);
        send_item(FUNC_UPDATE, 2'd3, 16'h7FFE, 32'hFFFF_FFFF);
        send_item(FUNC_UPDATE, 2'd3, 16'h0000, 32'hFFFF_FFFF);
        send_item(FUNC_UPDATE, 2'd0, 16'h0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_aging();
        send_item(FUNC_UPDATE, 2'd1, 16'h1234, 32'h0000_0000);
        send_item(FUNC_UPDATE, 2'd2, 16'hABCD, 32'h0A00_0001);
        repeat (3) send_item(FUNC_TICK, 2'd0, 16'h0000, 32'h0000_0000);
        send_item(FUNC_UPDATE, 2'd3, 16'h0001, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_shift();
        int i;
        set_silence(16'hFFFF);
        for (i = 0; i < 15; i++)
            send_item(FUNC_UPDATE, 2'(i), 16'(i * 7), 32'hC0A8_0000 + i);
    endtask

    task automatic test_silence_edge();
        set_silence(16'd2);
        send_item(FUNC_UPDATE, 2'd2, 16'h0100, 32'h5A5A_5A5A);
        repeat (2) send_item(FUNC_TICK, 2'd0, 16'h0000, 32'h0000_0000);
        send_item(FUNC_UPDATE, 2'd2, 16'h00FF, 32'h5A5A_5A5A);
        send_item(FUNC_TICK, 2'd0, 16'h0000, 32'h0000_0000);
        send_item(FUNC_UPDATE, 2'd2, 16'h00FF, 32'h5A5A_5A5A);
        send_item(FUNC_UPDATE, 2'd2, 16'h0101, 32'h5A5A_5A5A);
    endtask

    task automatic test_random_traffic(input logic [TICK_W-1:0] limit, input int count,
                                       input bit gaps);
        int          i;
        int          k;
        int          pool_size;
        int          tick_pct;
        int          r;
        int unsigned mode;
        logic [PORT_W-1:0] p;
        logic [SEQ_W-1:0]  s;
        logic [ADDR_W-1:0] a;
        set_silence(limit);
        gaps_on   = gaps;
        pool_size = $urandom_range(4, POOL_MAX);
        tick_pct  = $urandom_range(5, 40);
        for (i = 0; i < POOL_MAX; i++)
        begin
            pool_addr[i] = $urandom();
            pool_port[i] = 2'($urandom_range(0, 3));
            pool_seq[i]  = 16'($urandom());
        end
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < tick_pct)
                send_item(FUNC_TICK, 2'($urandom()), 16'($urandom()), $urandom());
            else if (r < 94)
            begin
                k = $urandom_range(0, pool_size - 1);
                p = ($urandom_range(0, 7) == 0) ? 2'($urandom()) : pool_port[k];
                mode = $urandom_range(0, 9);
                case (mode) inside
                    0:       s = pool_seq[k];
                    1:       s = pool_seq[k] + 16'h8000;
                    [2:3]:   s = pool_seq[k] - 16'($urandom_range(1, 16'h7FFF));
                    [8:9]:   s = 16'($urandom());
                    default: s = pool_seq[k] + 16'($urandom_range(1, 16'h7FFF));
                endcase
                pool_seq[k] = s;
                send_item(FUNC_UPDATE, p, s, pool_addr[k]);
            end
            else
            begin
                a = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
                send_item(FUNC_UPDATE, 2'($urandom()), 16'($urandom()), a);
            end
            if ($urandom_range(0, 63) == 0)
                wait_table_idle();
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            shadow_addr[i]  = '0;
            shadow_port[i]  = '0;
            shadow_seq[i]   = '0;
            shadow_heard[i] = '0;
        end
        shadow_tick    = '0;
        shadow_silence = SILENCE_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_serial_compare();
        test_aging();
        test_full_shift();
        test_silence_edge();
        test_random_traffic(16'd0, 170, 1'b1);
        test_random_traffic(16'hFFFF, 170, 1'b1);
        test_random_traffic(16'd2, 170, 1'b0);
        test_random_traffic(16'($urandom_range(1, 6)), 170, 1'b1);
        test_random_traffic(16'($urandom()), 170, 1'b1);
        test_random_traffic(16'd1, 170, 1'b1);

        wait_table_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input transfers (%0d ticks) with silence limits 0 to 65535",
                 n_in, n_ticks);
        $display("checked %0d results: %0d stored, %0d shift-downs",
                 n_out, n_stored, n_shifted);
        if (errors == 0 && outcome_q.size() == 0)
            $display("freshness_node_table_tb passed");
        else
            $display("freshness_node_table_tb failed");
        $finish;
    end

endmodule
